// ===== rtl/lps_pkg.sv =====
`default_nettype none
package lps_pkg;
   localparam int PatternDepth = 64;

   typedef struct packed {
      logic [1:0]  op;
      logic [5:0]  addr;
      logic [15:0] word;
   } req_type;

   typedef struct packed {
      logic        mono_pin;
      logic        red_pin;
      logic        green_pin;
      logic        blue_pin;
      logic [15:0] duty;
      logic        duty_active;
      logic [2:0]  run_state;
      logic [1:0]  status;
   } rsp_type;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_TICK  = 2'd1;
   localparam logic [1:0] OP_START = 2'd2;
   localparam logic [1:0] OP_STOP  = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_AGAIN   = 2'd1;
   localparam logic [1:0] ST_INVALID = 2'd2;
   localparam logic [1:0] ST_EMPTY   = 2'd3;

   localparam logic [2:0] RC_IDLE  = 3'd0;
   localparam logic [2:0] RC_READY = 3'd1;
   localparam logic [2:0] RC_EXEC  = 3'd2;
   localparam logic [2:0] RC_FADE  = 3'd3;
   localparam logic [2:0] RC_HOLD  = 3'd4;

   localparam logic [15:0] PC_ON     = 16'd1;
   localparam logic [15:0] PC_OFF    = 16'd2;
   localparam logic [15:0] PC_RGB    = 16'd3;
   localparam logic [15:0] PC_FADE   = 16'd4;
   localparam logic [15:0] PC_HOLD   = 16'd5;
   localparam logic [15:0] PC_REPEAT = 16'd6;
   localparam logic [15:0] PC_NONE   = 16'd0;

   localparam logic [1:0] CSR_ALLOW  = 2'd0;
   localparam logic [1:0] CSR_RGB    = 2'd1;
   localparam logic [1:0] CSR_LENGTH = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_FETCH, S_ARG, S_DECODE, S_DIV, S_DIVWAIT,
      S_DUTY, S_DUTYWAIT, S_FINISH, S_OUT
   } fsm_type;

   // controller -> datapath
   typedef struct packed {
      logic take;       // latch request word
      logic mem_read;   // read memory at word_index, advance
      logic arg_store;  // store read data as opcode, then as next argument
      logic exec;       // apply decoded command / tick effects
      logic div_start;
      logic div_fade;   // 1: divide for fade rate, 0: progress
      logic duty_calc;  // apply fade duty
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic       is_tick;
      logic       is_ready;
      logic       is_fade_tick;
      logic       fade_div;     // fade tick needs division
      logic       at_end;       // word_index >= limit
      logic [2:0] args_needed;
      logic [2:0] args_have;
      logic       have_opc;
      logic       div_busy;
      logic       div_needed;   // parse fade needs divider
   } sts_type;
endpackage
`default_nettype wire

// ===== rtl/lps_div.sv =====
`default_nettype none
module lps_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [16:0] dividend,
   input  wire logic [15:0] divisor,
   output logic             busy,
   output logic [16:0]      quotient
);
   logic [16:0] quot_ff, quot_in;
   logic [16:0] rem_ff, rem_in;
   logic [15:0] dsr_ff, dsr_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [17:0] trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = '0;
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = 5'd17;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         trial = {rem_ff, quot_ff[16]} - {2'b00, dsr_ff};
         if (!trial[17]) begin
            rem_in = trial[16:0];
         end else begin
            rem_in = {rem_ff[15:0], quot_ff[16]};
         end
         quot_in = {quot_ff[15:0], ~trial[17]};
         cnt_in  = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign busy     = busy_ff;
   assign quotient = quot_ff;
endmodule
`default_nettype wire

// ===== rtl/lps_datapath.sv =====
`default_nettype none
module lps_datapath #(
   parameter int PATTERN_DEPTH = lps_pkg::PatternDepth
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire lps_pkg::req_type req_data,
   input  wire lps_pkg::cmd_type cmd,
   output lps_pkg::sts_type      sts,
   output lps_pkg::rsp_type      rsp_data,
   input  wire logic             csr_we,
   input  wire logic [1:0]       csr_idx,
   input  wire logic [31:0]      csr_wdata,
   output logic [31:0]           csr_rdata
);
   localparam int AW = $clog2(PATTERN_DEPTH);
   localparam int LW = $clog2(PATTERN_DEPTH + 1);

   logic [15:0] mem [PATTERN_DEPTH];
   logic [15:0] rd_ff;

   logic allow_ff, rgbm_ff;
   logic [6:0] plen_ff;
   lps_pkg::req_type req_ff;

   logic [2:0]  rc_ff, rc_in;
   logic        act_ff, act_in;
   logic [LW-1:0] widx_ff, widx_in;
   logic [15:0] loop_ff, loop_in;
   logic [15:0] hel_ff, hel_in, hlim_ff, hlim_in;
   logic [15:0] ffrom_ff, ffrom_in, fto_ff, fto_in, ftime_ff, ftime_in;
   logic [15:0] frate_ff, frate_in;
   logic [1:0]  fflag_ff, fflag_in;
   logic [16:0] fel_ff, fel_in;
   logic [3:0]  pins_ff, pins_in;
   logic [15:0] duty_ff, duty_in;
   logic [1:0]  st_ff, st_in;
   logic [15:0] opc_ff, opc_in;
   logic [15:0] arg_ff [4];
   logic [2:0]  nargs_ff, nargs_in;
   logic        hopc_ff, hopc_in;

   logic [LW-1:0] limit;
   logic          at_end;
   logic [15:0]   delta;
   logic          down;
   logic          ticks;
   logic          div_start;
   logic [16:0]   dvd;
   logic [15:0]   dvs;
   logic          div_busy;
   logic [16:0]   quo;
   logic [31:0]   prog;
   logic [2:0]    need;
   logic [17:0]   upsum;

   assign limit  = (int'(plen_ff) < PATTERN_DEPTH) ? LW'(plen_ff) : LW'(PATTERN_DEPTH);
   assign at_end = widx_ff >= limit;

   // fade parse values from args
   always_comb begin
      down  = !(arg_ff[1] > arg_ff[0]);
      delta = down ? arg_ff[0] - arg_ff[1] : arg_ff[1] - arg_ff[0];
      ticks = arg_ff[2] > delta;
   end

   always_comb begin
      div_start = cmd.div_start;
      if (cmd.div_fade) begin
         dvd = ticks ? {1'b0, arg_ff[2]} : {1'b0, delta};
         dvs = ticks ? delta : arg_ff[2];
      end else begin
         dvd = fel_ff;
         dvs = frate_ff;
      end
   end

   lps_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(dvd),
      .divisor (dvs),
      .busy    (div_busy),
      .quotient(quo)
   );

   always_comb begin
      unique case (opc_ff)
         lps_pkg::PC_ON, lps_pkg::PC_OFF, lps_pkg::PC_REPEAT: need = 3'd1;
         lps_pkg::PC_RGB:  need = 3'd4;
         lps_pkg::PC_FADE: need = 3'd3;
         lps_pkg::PC_HOLD: need = 3'd2;
         default:          need = 3'd0;
      endcase
   end

   assign sts.is_tick      = req_ff.op == lps_pkg::OP_TICK;
   assign sts.is_ready     = rc_ff == lps_pkg::RC_READY && act_ff && !at_end;
   assign sts.is_fade_tick = rc_ff == lps_pkg::RC_FADE && {1'b0, fel_ff} <= {2'b00, ftime_ff};
   assign sts.fade_div     = ftime_ff != 16'd0 && frate_ff != 16'd0 && fflag_ff[1];
   assign sts.at_end       = at_end;
   assign sts.args_needed  = need;
   assign sts.args_have    = nargs_ff;
   assign sts.have_opc     = hopc_ff;
   assign sts.div_busy     = div_busy;
   assign sts.div_needed   = opc_ff == lps_pkg::PC_FADE && nargs_ff == 3'd3
                             && (ticks ? delta != 16'd0 : arg_ff[2] != 16'd0);

   always_comb begin
      prog = fflag_ff[1] ? {15'd0, quo} : {15'd0, fel_ff} * {16'd0, frate_ff};
   end
   assign upsum = {2'b00, ffrom_ff} + prog[17:0];

   always_comb begin
      rc_in    = rc_ff;
      act_in   = act_ff;
      widx_in  = widx_ff;
      loop_in  = loop_ff;
      hel_in   = hel_ff;
      hlim_in  = hlim_ff;
      ffrom_in = ffrom_ff;
      fto_in   = fto_ff;
      ftime_in = ftime_ff;
      frate_in = frate_ff;
      fflag_in = fflag_ff;
      fel_in   = fel_ff;
      pins_in  = pins_ff;
      duty_in  = duty_ff;
      st_in    = st_ff;
      opc_in   = opc_ff;
      nargs_in = nargs_ff;
      hopc_in  = hopc_ff;
      if (cmd.take) begin
         st_in    = lps_pkg::ST_OK;
         nargs_in = '0;
         hopc_in  = 1'b0;
         opc_in   = '0;
      end
      if (cmd.mem_read) begin
         widx_in = widx_ff + LW'(1);
      end
      if (cmd.arg_store) begin
         if (!hopc_ff) begin
            opc_in  = rd_ff;
            hopc_in = 1'b1;
         end else begin
            nargs_in = nargs_ff + 3'd1;
         end
      end
      if (cmd.div_start && cmd.div_fade) begin
         frate_in = '0;
      end
      if (cmd.duty_calc) begin
         if (ftime_ff == 16'd0) begin
            duty_in = fto_ff;
         end else if (frate_ff == 16'd0) begin
            duty_in = ffrom_ff;
         end else if (fflag_ff[0]) begin
            if (prog >= {16'd0, ffrom_ff - fto_ff}) begin
               duty_in = fto_ff;
            end else begin
               duty_in = ffrom_ff - prog[15:0];
            end
         end else if (upsum > 18'hFFFF || prog[31:18] != '0) begin
            duty_in = 16'hFFFF;
         end else begin
            duty_in = upsum[15:0];
         end
         fel_in = fel_ff + 17'd1;
      end
      if (cmd.exec) begin
         unique case (req_ff.op)
            lps_pkg::OP_LOAD: ;
            lps_pkg::OP_START: begin
               act_in  = 1'b1;
               rc_in   = lps_pkg::RC_READY;
               widx_in = '0;
               loop_in = '0;
               pins_in = rgbm_ff ? {3'b000, pins_ff[0]} : {pins_ff[3:1], 1'b0};
            end
            lps_pkg::OP_STOP: begin
               act_in  = 1'b0;
               rc_in   = lps_pkg::RC_IDLE;
               widx_in = '0;
               pins_in = rgbm_ff ? {3'b000, pins_ff[0]} : {pins_ff[3:1], 1'b0};
            end
            default: begin
               unique case (rc_ff)
                  lps_pkg::RC_READY: begin
                     if (!act_ff) begin
                        rc_in = lps_pkg::RC_IDLE;
                        st_in = lps_pkg::ST_INVALID;
                     end else if (!hopc_ff) begin
                        rc_in  = lps_pkg::RC_IDLE;
                        act_in = 1'b0;
                        st_in  = lps_pkg::ST_OK;
                     end else if (opc_ff == lps_pkg::PC_NONE) begin
                        rc_in  = lps_pkg::RC_IDLE;
                        act_in = 1'b0;
                        st_in  = lps_pkg::ST_AGAIN;
                     end else if (need == 3'd0) begin
                        rc_in  = lps_pkg::RC_IDLE;
                        act_in = 1'b0;
                        st_in  = lps_pkg::ST_INVALID;
                     end else if (nargs_ff != need) begin
                        rc_in  = lps_pkg::RC_IDLE;
                        act_in = 1'b0;
                        st_in  = opc_ff == lps_pkg::PC_FADE ? lps_pkg::ST_EMPTY
                                                             : lps_pkg::ST_INVALID;
                     end else begin
                        unique case (opc_ff)
                           lps_pkg::PC_ON, lps_pkg::PC_OFF: begin
                              hlim_in = arg_ff[0];
                              hel_in  = '0;
                              rc_in   = lps_pkg::RC_EXEC;
                              if (rgbm_ff) begin
                                 pins_in = {{3{opc_ff == lps_pkg::PC_ON}}, pins_ff[0]};
                              end else begin
                                 pins_in = {pins_ff[3:1], opc_ff == lps_pkg::PC_ON};
                              end
                           end
                           lps_pkg::PC_RGB: begin
                              hlim_in = arg_ff[3];
                              hel_in  = '0;
                              rc_in   = lps_pkg::RC_EXEC;
                              pins_in = {arg_ff[2] != 16'd0, arg_ff[1] != 16'd0,
                                         arg_ff[0] != 16'd0, pins_ff[0]};
                           end
                           lps_pkg::PC_FADE: begin
                              ffrom_in = arg_ff[0];
                              fto_in   = arg_ff[1];
                              ftime_in = arg_ff[2];
                              fflag_in = {ticks, down};
                              if (sts.div_needed) begin
                                 frate_in = quo[15:0];
                              end else begin
                                 frate_in = '0;
                              end
                              fel_in = '0;
                              rc_in  = lps_pkg::RC_FADE;
                           end
                           lps_pkg::PC_HOLD: begin
                              duty_in = arg_ff[0];
                              hlim_in = arg_ff[1];
                              hel_in  = '0;
                              rc_in   = lps_pkg::RC_HOLD;
                           end
                           default: begin
                              if ((arg_ff[0] != 16'd0 && loop_ff < arg_ff[0] - 16'd1)
                                  || (allow_ff && arg_ff[0] == 16'd0)) begin
                                 rc_in   = lps_pkg::RC_READY;
                                 widx_in = '0;
                                 loop_in = loop_ff + 16'd1;
                              end else begin
                                 act_in = 1'b0;
                                 rc_in  = lps_pkg::RC_IDLE;
                              end
                           end
                        endcase
                     end
                  end
                  lps_pkg::RC_EXEC, lps_pkg::RC_HOLD: begin
                     if (hel_ff != 16'hFFFF) begin
                        hel_in = hel_ff + 16'd1;
                     end
                     if (hel_in >= hlim_ff) begin
                        rc_in = lps_pkg::RC_READY;
                     end
                  end
                  lps_pkg::RC_FADE: begin
                     if (!sts.is_fade_tick) begin
                        rc_in = lps_pkg::RC_READY;
                     end
                  end
                  lps_pkg::RC_IDLE: begin
                     if (act_ff) begin
                        rc_in = lps_pkg::RC_READY;
                     end
                     loop_in = '0;
                     widx_in = '0;
                     st_in   = lps_pkg::ST_AGAIN;
                  end
                  default: begin
                     rc_in = lps_pkg::RC_IDLE;
                     st_in = lps_pkg::ST_INVALID;
                  end
               endcase
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         req_ff <= req_data;
      end
      if (cmd.exec && req_ff.op == lps_pkg::OP_LOAD && 32'(req_ff.addr) < PATTERN_DEPTH) begin
         mem[AW'(req_ff.addr)] <= req_ff.word;
      end
      if (cmd.mem_read) begin
         rd_ff <= mem[widx_ff[AW-1:0]];
      end
      if (cmd.arg_store && hopc_ff) begin
         arg_ff[nargs_ff[1:0]] <= rd_ff;
      end
      opc_ff   <= opc_in;
      nargs_ff <= nargs_in;
      hopc_ff  <= hopc_in;
      st_ff    <= st_in;
      if (reset) begin
         allow_ff <= 1'b1;
         rgbm_ff  <= 1'b0;
         plen_ff  <= '0;
         rc_ff    <= lps_pkg::RC_IDLE;
         act_ff   <= 1'b0;
         widx_ff  <= '0;
         loop_ff  <= '0;
         hel_ff   <= '0;
         hlim_ff  <= '0;
         ffrom_ff <= '0;
         fto_ff   <= '0;
         ftime_ff <= '0;
         frate_ff <= '0;
         fflag_ff <= '0;
         fel_ff   <= '0;
         pins_ff  <= '0;
         duty_ff  <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_idx)
               lps_pkg::CSR_ALLOW:  allow_ff <= csr_wdata[0];
               lps_pkg::CSR_RGB:    rgbm_ff  <= csr_wdata[0];
               lps_pkg::CSR_LENGTH: plen_ff  <= csr_wdata[6:0];
               default: ;
            endcase
         end
         rc_ff    <= rc_in;
         act_ff   <= act_in;
         widx_ff  <= widx_in;
         loop_ff  <= loop_in;
         hel_ff   <= hel_in;
         hlim_ff  <= hlim_in;
         ffrom_ff <= ffrom_in;
         fto_ff   <= fto_in;
         ftime_ff <= ftime_in;
         frate_ff <= frate_in;
         fflag_ff <= fflag_in;
         fel_ff   <= fel_in;
         pins_ff  <= pins_in;
         duty_ff  <= duty_in;
      end
   end

   always_comb begin
      unique case (csr_idx)
         lps_pkg::CSR_ALLOW:  csr_rdata = {31'd0, allow_ff};
         lps_pkg::CSR_RGB:    csr_rdata = {31'd0, rgbm_ff};
         lps_pkg::CSR_LENGTH: csr_rdata = {25'd0, plen_ff};
         default:             csr_rdata = '0;
      endcase
   end

   assign rsp_data.mono_pin    = pins_ff[0];
   assign rsp_data.red_pin     = pins_ff[1];
   assign rsp_data.green_pin   = pins_ff[2];
   assign rsp_data.blue_pin    = pins_ff[3];
   assign rsp_data.duty        = duty_ff;
   assign rsp_data.duty_active = rc_ff == lps_pkg::RC_FADE || rc_ff == lps_pkg::RC_HOLD;
   assign rsp_data.run_state   = rc_ff;
   assign rsp_data.status      = st_ff;
endmodule
`default_nettype wire

// ===== rtl/lps_ctrl.sv =====
`default_nettype none
module lps_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   input  wire lps_pkg::sts_type sts,
   output lps_pkg::cmd_type      cmd
);
   lps_pkg::fsm_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lps_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = state_ff != lps_pkg::S_IDLE;
   assign rsp_valid = state_ff == lps_pkg::S_OUT;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         lps_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = lps_pkg::S_DISPATCH;
            end
         end
         lps_pkg::S_DISPATCH: begin
            if (sts.is_tick && sts.is_ready) begin
               cmd.mem_read = 1'b1;
               state_in     = lps_pkg::S_FETCH;
            end else if (sts.is_tick && sts.is_fade_tick && sts.fade_div) begin
               cmd.div_start = 1'b1;
               state_in      = lps_pkg::S_DUTYWAIT;
            end else if (sts.is_tick && sts.is_fade_tick) begin
               state_in = lps_pkg::S_DUTY;
            end else begin
               state_in = lps_pkg::S_FINISH;
            end
         end
         lps_pkg::S_FETCH: begin
            cmd.arg_store = 1'b1;
            state_in      = lps_pkg::S_ARG;
         end
         lps_pkg::S_ARG: begin
            if (sts.have_opc && sts.args_have < sts.args_needed && !sts.at_end) begin
               cmd.mem_read = 1'b1;
               state_in     = lps_pkg::S_FETCH;
            end else begin
               state_in = lps_pkg::S_DECODE;
            end
         end
         lps_pkg::S_DECODE: begin
            if (sts.div_needed) begin
               cmd.div_start = 1'b1;
               cmd.div_fade  = 1'b1;
               state_in      = lps_pkg::S_DIV;
            end else begin
               state_in = lps_pkg::S_FINISH;
            end
         end
         lps_pkg::S_DIV: begin
            if (!sts.div_busy) begin
               state_in = lps_pkg::S_FINISH;
            end
         end
         lps_pkg::S_DUTYWAIT: begin
            if (!sts.div_busy) begin
               state_in = lps_pkg::S_DUTY;
            end
         end
         lps_pkg::S_DUTY: begin
            cmd.duty_calc = 1'b1;
            state_in      = lps_pkg::S_OUT;
         end
         lps_pkg::S_FINISH: begin
            cmd.exec = 1'b1;
            state_in = lps_pkg::S_OUT;
         end
         lps_pkg::S_OUT: begin
            if (!rsp_stall) begin
               state_in = lps_pkg::S_IDLE;
            end
         end
         default: state_in = lps_pkg::S_IDLE;
      endcase
   end
endmodule
`default_nettype wire

// ===== rtl/led_pattern_sequencer.sv =====
`default_nettype none
// LED pattern sequencer. Load program words with op 0, start with op 2, stop with op 3 and
// advance with op 1 once per millisecond; every word gives one response word. A tick that
// decodes a command reads each program word from the single-port pattern memory in turn,
// and a fade decode or a fade tick with a slow rate also waits on the serial divider.
// Inputs are held off until the response has been taken.
module led_pattern_sequencer #(
   parameter int PATTERN_DEPTH = lps_pkg::PatternDepth
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire lps_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output lps_pkg::rsp_type      rsp_data,
   input  wire logic             psel,
   input  wire logic             penable,
   input  wire logic             pwrite,
   input  wire logic [3:0]       paddr,
   input  wire logic [31:0]      pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);
   lps_pkg::cmd_type cmd;
   lps_pkg::sts_type sts;
   logic csr_we;

   assign pready = 1'b1;
   assign csr_we = psel && penable && pwrite;

   lps_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .sts      (sts),
      .cmd      (cmd)
   );

   lps_datapath #(.PATTERN_DEPTH(PATTERN_DEPTH)) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data),
      .csr_we   (csr_we && paddr[1:0] == 2'b00),
      .csr_idx  (paddr[3:2]),
      .csr_wdata(pwdata),
      .csr_rdata(prdata)
   );
endmodule
`default_nettype wire
